>>> sv/rilbp_pkg.sv
package rilbp_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_W      = 128;
    localparam int COL_W      = $clog2(MAX_W);
    localparam int ROW_W      = 12;
    localparam int FW_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 8'd128;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd64;
    localparam logic [FW_W-1:0]  MIN_WIDTH        = 8'd3;
    localparam logic [FW_W-1:0]  MAX_WIDTH_V      = 8'd128;
    localparam logic [ROW_W-1:0] MIN_HEIGHT       = 12'd3;

    // 3x3 neighbourhood around the centre pixel
    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] br;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] l;
        logic [PIX_W-1:0] c;
    } t_nbr;

endpackage

>>> sv/rilbp_line_buf.sv
module rilbp_line_buf
    import rilbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_upper,
    input  logic [PIX_W-1:0] i_wr_mid,
    input  logic [COL_W-1:0] i_rd_addr,
    output logic [PIX_W-1:0] o_rd_upper,
    output logic [PIX_W-1:0] o_rd_mid
);

    logic [PIX_W-1:0] r_upper [MAX_W];
    logic [PIX_W-1:0] r_mid   [MAX_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_upper[i_wr_addr] <= i_wr_upper;
            r_mid[i_wr_addr]   <= i_wr_mid;
        end
    end

    // read address is the column of the next word, so data is ready when it arrives
    always_ff @(posedge i_clk) begin
        o_rd_upper <= r_upper[i_rd_addr];
        o_rd_mid   <= r_mid[i_rd_addr];
    end

endmodule

>>> sv/rilbp_code.sv
module rilbp_code
    import rilbp_pkg::*;
(
    input  t_nbr       i_nbr,
    output logic [7:0] o_code
);

    logic [7:0] bits;
    logic [7:0] rot  [8];
    logic [7:0] min4 [4];
    logic [7:0] min2 [2];

    always_comb begin
        bits = {i_nbr.tl >= i_nbr.c, i_nbr.t  >= i_nbr.c, i_nbr.tr >= i_nbr.c,
                i_nbr.r  >= i_nbr.c, i_nbr.br >= i_nbr.c, i_nbr.b  >= i_nbr.c,
                i_nbr.bl >= i_nbr.c, i_nbr.l  >= i_nbr.c};
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rot[k] = 8'(({bits, bits} << k) >> 8);
        end
    end

    // three-level minimum tree
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            min4[i] = (rot[2*i] < rot[2*i+1]) ? rot[2*i] : rot[2*i+1];
        end
        for (int i = 0; i < 2; i++) begin
            min2[i] = (min4[2*i] < min4[2*i+1]) ? min4[2*i] : min4[2*i+1];
        end
        o_code = (min2[0] < min2[1]) ? min2[0] : min2[1];
    end

endmodule

>>> sv/rotation_invariant_lbp_3x3.sv
// channel | valid      | stall       | payload
// pixels  | i_in_valid | o_in_stall  | i_pixel_value
// codes   | o_out_valid| i_out_stall | o_pattern_code, o_row_end, o_frame_end
// config  | i_cfg_we   | -           | i_cfg_index, i_cfg_data
//
// One word per cycle in while the output is not stalled; a code leaves in the
// cycle after the pixel below and right of its centre is taken. The line buffers
// are read one word ahead from the column counter, so nothing else sets the rate.
// Reset or a write to the frame width or height restarts the frame at the top-left pixel.
// The input stalls only while a finished code waits at a stalled output.
module rotation_invariant_lbp_3x3
    import rilbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_pattern_code,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    logic [FW_W-1:0]  r_width;
    logic [ROW_W-1:0] r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_win [6];
    logic             r_out_valid;
    logic [7:0]       r_code;
    logic             r_row_end;
    logic             r_frame_end;

    logic [FW_W-1:0]  eff_w;
    logic [FW_W-1:0]  eff_w_m1;
    logic [ROW_W-1:0] eff_h_m1;
    logic             en;
    logic             acc;
    logic             cfg_hit;
    logic             interior;
    logic             last_col;
    logic             last_row;
    logic [PIX_W-1:0] rd_upper;
    logic [PIX_W-1:0] rd_mid;
    t_nbr             nbr;
    logic [7:0]       code;

    always_comb begin
        eff_w = r_width;
        if (r_width < MIN_WIDTH) begin
            eff_w = MIN_WIDTH;
        end else if (r_width > MAX_WIDTH_V) begin
            eff_w = MAX_WIDTH_V;
        end
        eff_w_m1 = eff_w - 8'd1;
        eff_h_m1 = ((r_height < MIN_HEIGHT) ? MIN_HEIGHT : r_height) - 12'd1;
    end

    assign en       = !r_out_valid || !i_out_stall;
    assign acc      = i_in_valid && en;
    assign cfg_hit  = i_cfg_we &&
                      (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);
    assign last_col = ({1'b0, r_col} == eff_w_m1);
    assign last_row = (r_row == eff_h_m1);
    assign interior = (r_row >= 12'd2) && (r_col >= 7'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FRAME_WIDTH_RST;
            r_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 12'd1;
            end else begin
                n_col = r_col + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    rilbp_line_buf u_line_buf (
        .i_clk      (i_clk),
        .i_we       (acc),
        .i_wr_addr  (r_col),
        .i_wr_upper (rd_mid),
        .i_wr_mid   (i_pixel_value),
        .i_rd_addr  (n_col),
        .o_rd_upper (rd_upper),
        .o_rd_mid   (rd_mid)
    );

    // window: 0..2 column before last (top, mid, bottom), 3..5 last column
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= rd_upper;
            r_win[4] <= rd_mid;
            r_win[5] <= i_pixel_value;
        end
    end

    always_comb begin
        nbr.tl = r_win[0];
        nbr.t  = r_win[3];
        nbr.tr = rd_upper;
        nbr.r  = rd_mid;
        nbr.br = i_pixel_value;
        nbr.b  = r_win[5];
        nbr.bl = r_win[2];
        nbr.l  = r_win[1];
        nbr.c  = r_win[4];
    end

    rilbp_code u_code (
        .i_nbr  (nbr),
        .o_code (code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= acc && interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_code      <= code;
            r_row_end   <= last_col;
            r_frame_end <= last_col && last_row;
        end
    end

    assign o_in_stall     = !en;
    assign o_out_valid    = r_out_valid;
    assign o_pattern_code = r_code;
    assign o_row_end      = r_row_end;
    assign o_frame_end    = r_frame_end;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} <= eff_w_m1 || $past(i_cfg_we)))
        else $error("column counter beyond row width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= eff_h_m1 || $past(i_cfg_we)))
        else $error("row counter beyond frame height");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");

    a_interior_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && interior) |=> o_out_valid)
        else $error("interior word gave no code");

endmodule
